FILE: rtl/svp_pkg.sv
`timescale 1ns / 1ps
package svp_pkg;
	localparam int INDEX_BITS  = 10;
	localparam int TAG_BITS    = 8;
	localparam int QUEUE_DEPTH = 256;
	localparam int ENTRIES     = 1 << INDEX_BITS;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int KEY_BITS    = TAG_BITS + INDEX_BITS;
	localparam int INST_BITS   = QPTR_BITS + 1;
	localparam int CONF_BITS   = 4;
	localparam int OCC_BITS    = QPTR_BITS + 1;
	localparam logic [INST_BITS-1:0] INST_MAX = {INST_BITS{1'b1}};

	localparam logic [2:0] MODE_ALLOC   = 3'd0;
	localparam logic [2:0] MODE_QUERY   = 3'd1;
	localparam logic [2:0] MODE_TRAIN   = 3'd2;
	localparam logic [2:0] MODE_SQUASH  = 3'd3;
	localparam logic [2:0] MODE_RECOVER = 3'd4;

	typedef struct packed {
		logic [2:0]  mode;
		logic [63:0] pc;
		logic [63:0] value;
		logic [7:0]  target_entry;
		logic        target_phase;
		logic [8:0]  bundle_count;
	} svp_in_t;

	typedef struct packed {
		logic        hit;
		logic        confident;
		logic [63:0] predicted_value;
		logic [7:0]  slot;
		logic        slot_phase;
		logic        stall_res;
	} svp_out_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture item, start table read
		logic eval;      // table data valid: compute, latch flags
		logic mult;      // product stage
		logic commit;    // write entry / pointers, emit result
		logic scan_rd;   // issue queue read at scan pointer
		logic scan_chk;  // compare read key
		logic tail_rd;   // retreat tail, read key
		logic tail_rd2;  // read entry for tail key
		logic tail_wr;   // undo instance
		logic clr_wr;    // clearing pass write
	} svp_cmd_t;

	typedef struct packed {
		logic       mode_alloc;
		logic       mode_train;
		logic       mode_walk;   // squash or recover
		logic       train_miss;
		logic       scan_done;
		logic       walk_done;
		logic       clr_done;
	} svp_sts_t;
endpackage

FILE: rtl/svp_datapath.sv
`timescale 1ns / 1ps
module svp_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  svp_pkg::svp_cmd_t     cmd,
	output svp_pkg::svp_sts_t     sts,
	input  svp_pkg::svp_in_t      in_item,
	input  logic [3:0]            conf_limit,
	output svp_pkg::svp_out_t     res,
	output logic                  res_strobe
);
	localparam int IB = svp_pkg::INDEX_BITS;
	localparam int TB = svp_pkg::TAG_BITS;
	localparam int QB = svp_pkg::QPTR_BITS;
	localparam int NB = svp_pkg::INST_BITS;
	localparam int OB = svp_pkg::OCC_BITS;
	localparam int KB = svp_pkg::KEY_BITS;

	logic [TB-1:0]  tag_mem  [svp_pkg::ENTRIES];
	logic [3:0]     conf_mem [svp_pkg::ENTRIES];
	logic [63:0]    ret_mem  [svp_pkg::ENTRIES];
	logic [63:0]    str_mem  [svp_pkg::ENTRIES];
	logic [NB-1:0]  inst_mem [svp_pkg::ENTRIES];
	logic [KB-1:0]  key_mem  [svp_pkg::QUEUE_DEPTH];

	svp_pkg::svp_in_t item_q;
	logic [IB-1:0] ix_q, rd_ix;
	logic [TB-1:0] tg_q;
	logic [TB-1:0] rtag_q;
	logic [3:0]    rconf_q;
	logic [63:0]   rret_q, rstr_q;
	logic [NB-1:0] rinst_q;
	logic [KB-1:0] rkey_q;

	logic [QB-1:0] head_q, tail_q, scan_q;
	logic          hph_q, tph_q;
	logic [OB-1:0] left_q, cnt_q;
	logic [IB-1:0] clr_q;
	logic          clr_done_q;

	logic          hit_q, full_q;
	logic [OB-1:0] occ_q;
	logic [63:0]   prod_s1;
	logic [NB-1:0] inst_use;
	logic [OB-1:0] occ, back;
	logic [OB:0]   rpos_t, rpos_h;
	logic [63:0]   ns;
	logic [4:0]    cinc;
	logic [3:0]    cnew;
	logic          walk_ok;
	logic [NB-1:0] cnt_sat;
	svp_pkg::svp_out_t res_d;

	assign rpos_t = {1'b0, tph_q, tail_q};
	assign rpos_h = {1'b0, hph_q, head_q};
	assign occ    = OB'(rpos_t - rpos_h);
	assign back   = OB'(rpos_t - {1'b0, item_q.target_phase, item_q.target_entry[QB-1:0]});

	assign rd_ix  = cmd.load ? in_item.pc[2 +: IB]
	                         : rkey_q[IB-1:0];

	// table read port (registered)
	always_ff @(posedge clk) begin
		if (cmd.load || cmd.tail_rd2) begin
			rtag_q  <= tag_mem[rd_ix];
			rconf_q <= conf_mem[rd_ix];
			rret_q  <= ret_mem[rd_ix];
			rstr_q  <= str_mem[rd_ix];
			rinst_q <= inst_mem[rd_ix];
		end
	end

	// queue read port
	always_ff @(posedge clk) begin
		if (cmd.scan_rd)
			rkey_q <= key_mem[scan_q];
		else if (cmd.tail_rd)
			rkey_q <= key_mem[tail_q - QB'(1)];
	end

	assign inst_use = (!full_q && rinst_q != svp_pkg::INST_MAX) ? rinst_q + NB'(1) : rinst_q;
	assign ns       = item_q.value - rret_q;
	assign cinc     = {1'b0, rconf_q} + 5'd1;
	assign cnew     = (cinc >= {1'b0, conf_limit}) ? conf_limit : cinc[3:0];
	assign cnt_sat  = NB'(cnt_q);
	assign walk_ok  = (item_q.mode == svp_pkg::MODE_SQUASH) ||
	                  (back <= occ_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_item;
			ix_q   <= in_item.pc[2 +: IB];
			tg_q   <= in_item.pc[2 + IB +: TB];
			occ_q  <= occ;
		end
		if (cmd.eval) begin
			hit_q  <= (rtag_q == tg_q);
			full_q <= (occ_q == OB'(svp_pkg::QUEUE_DEPTH));
		end
		if (cmd.mult)
			prod_s1 <= rstr_q * 64'(rinst_q);
	end

	// memory writes
	always_ff @(posedge clk) begin
		if (cmd.clr_wr) begin
			tag_mem[clr_q]  <= '0;
			conf_mem[clr_q] <= '0;
			ret_mem[clr_q]  <= '0;
			str_mem[clr_q]  <= '0;
			inst_mem[clr_q] <= '0;
		end else if (cmd.commit) begin
			if (item_q.mode == svp_pkg::MODE_ALLOC) begin
				if (!full_q)
					key_mem[tail_q] <= {tg_q, ix_q};
				if (hit_q)
					inst_mem[ix_q] <= inst_use;
			end else if (item_q.mode == svp_pkg::MODE_TRAIN && occ_q != '0) begin
				if (hit_q) begin
					if (ns == rstr_q)
						conf_mem[ix_q] <= cnew;
					else begin
						conf_mem[ix_q] <= '0;
						str_mem[ix_q]  <= ns;
					end
					ret_mem[ix_q]  <= item_q.value;
					if (rinst_q != '0)
						inst_mem[ix_q] <= rinst_q - NB'(1);
				end else begin
					tag_mem[ix_q]  <= tg_q;
					conf_mem[ix_q] <= '0;
					ret_mem[ix_q]  <= item_q.value;
					str_mem[ix_q]  <= item_q.value;
					inst_mem[ix_q] <= cnt_sat;
				end
			end
		end else if (cmd.tail_wr) begin
			if (rtag_q == rkey_q[KB-1:IB] && rinst_q != '0)
				inst_mem[rkey_q[IB-1:0]] <= rinst_q - NB'(1);
		end
	end

	always_comb begin
		res_d = '0;
		case (item_q.mode)
			svp_pkg::MODE_ALLOC: begin
				res_d.slot       = 8'(tail_q);
				res_d.slot_phase = tph_q;
				if (hit_q) begin
					res_d.hit       = 1'b1;
					res_d.confident = (rconf_q == conf_limit);
					res_d.predicted_value = full_q ? rret_q + prod_s1
					                               : rret_q + prod_s1 + rstr_q
					                                 - (rinst_q == svp_pkg::INST_MAX
					                                    ? rstr_q : 64'd0);
				end
			end
			svp_pkg::MODE_QUERY: begin
				res_d.stall_res = (occ_q == OB'(svp_pkg::QUEUE_DEPTH)) ||
				                  ((OB'(svp_pkg::QUEUE_DEPTH) - occ_q)
				                   < item_q.bundle_count);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0; tail_q <= '0; hph_q <= 1'b0; tph_q <= 1'b0;
			scan_q <= '0; left_q <= '0; cnt_q <= '0;
			clr_q <= '0; clr_done_q <= 1'b0;
			res_strobe <= 1'b0; res <= '0;
		end else begin
			res_strobe <= cmd.commit;
			if (cmd.clr_wr) begin
				clr_q <= clr_q + IB'(1);
				if (clr_q == {IB{1'b1}})
					clr_done_q <= 1'b1;
			end
			if (cmd.eval) begin
				scan_q <= head_q + QB'(1);
				cnt_q  <= '0;
				if (item_q.mode == svp_pkg::MODE_SQUASH)
					left_q <= occ_q;
				else if (item_q.mode == svp_pkg::MODE_RECOVER)
					left_q <= walk_ok ? back : '0;
				else
					left_q <= (occ_q == '0) ? '0 : occ_q - OB'(1);
			end
			if (cmd.scan_rd) begin
				scan_q <= scan_q + QB'(1);
				left_q <= left_q - OB'(1);
			end
			if (cmd.scan_chk && rkey_q == {tg_q, ix_q})
				cnt_q <= cnt_q + OB'(1);
			if (cmd.tail_rd) begin
				tail_q <= tail_q - QB'(1);
				if (tail_q == '0)
					tph_q <= ~tph_q;
				left_q <= left_q - OB'(1);
			end
			if (cmd.commit) begin
				res <= res_d;
				case (item_q.mode)
					svp_pkg::MODE_ALLOC: begin
						if (!full_q) begin
							tail_q <= tail_q + QB'(1);
							if (tail_q == {QB{1'b1}})
								tph_q <= ~tph_q;
						end
					end
					svp_pkg::MODE_TRAIN: begin
						if (occ_q != '0) begin
							head_q <= head_q + QB'(1);
							if (head_q == {QB{1'b1}})
								hph_q <= ~hph_q;
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign sts.mode_alloc = (item_q.mode == svp_pkg::MODE_ALLOC);
	assign sts.mode_train = (item_q.mode == svp_pkg::MODE_TRAIN) && occ_q != '0;
	assign sts.mode_walk  = (item_q.mode == svp_pkg::MODE_SQUASH) ||
	                        (item_q.mode == svp_pkg::MODE_RECOVER);
	assign sts.train_miss = !hit_q;
	assign sts.scan_done  = (left_q == '0);
	assign sts.walk_done  = (left_q == '0);
	assign sts.clr_done   = clr_done_q;
endmodule

FILE: rtl/svp_ctrl.sv
`timescale 1ns / 1ps
module svp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output svp_pkg::svp_cmd_t  cmd,
	input  svp_pkg::svp_sts_t  sts
);
	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_READ, S_EVAL, S_SCAN, S_SCHK,
		S_TRD, S_TRD2, S_TWR, S_COMMIT
	} state_t;

	state_t state_q;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			S_CLEAR:  cmd.clr_wr   = 1'b1;
			S_IDLE:   cmd.load     = start;
			S_READ:   cmd.eval     = 1'b1;
			S_EVAL:   cmd.mult     = 1'b1;
			S_SCAN:   cmd.scan_rd  = 1'b1;
			S_SCHK:   begin cmd.scan_chk = 1'b1; cmd.scan_rd = !sts.scan_done; end
			S_TRD:    cmd.tail_rd  = 1'b1;
			S_TRD2:   cmd.tail_rd2 = 1'b1;
			S_TWR:    cmd.tail_wr  = 1'b1;
			S_COMMIT: cmd.commit   = 1'b1;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			case (state_q)
				S_CLEAR:  if (sts.clr_done) state_q <= S_IDLE;
				S_IDLE:   if (start) state_q <= S_READ;
				S_READ:   state_q <= S_EVAL;
				S_EVAL: begin
					if (sts.mode_walk)
						state_q <= sts.walk_done ? S_COMMIT : S_TRD;
					else if (sts.mode_train && sts.train_miss)
						state_q <= sts.scan_done ? S_COMMIT : S_SCAN;
					else
						state_q <= S_COMMIT;
				end
				S_SCAN:   state_q <= S_SCHK;
				S_SCHK:   if (sts.scan_done) state_q <= S_COMMIT;
				S_TRD:    state_q <= S_TRD2;
				S_TRD2:   state_q <= S_TWR;
				S_TWR:    state_q <= sts.walk_done ? S_COMMIT : S_TRD;
				S_COMMIT: state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/stride_value_predictor_unit.sv
`timescale 1ns / 1ps
// Stride value predictor with in-flight queue.
// Items: raise start with in_item while busy is low; the item is taken at
// that edge. One result per item appears on res for exactly one cycle with
// res_strobe high; the receiver cannot stall it.
// Flow: allocate, stall query, train hit and idle modes put the result
// out after table read, evaluate and multiply, and commit; busy is low
// again in the same cycle that res_strobe is high. Train miss adds a scan
// of the other occupied slots for the queue count; squash and recover add
// a key read, an entry read and an entry write per slot walked back. One
// item in flight at a time.
// Reset: pointers clear, then a clearing pass zeroes the predictor table;
// busy stays high meanwhile. max_confidence resets to 3; the user must
// write it over APB at address 0 only while idle; the block has no check for this.
module stride_value_predictor_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  svp_pkg::svp_in_t   in_item,
	output svp_pkg::svp_out_t  res,
	output logic               res_strobe,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [0:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	svp_pkg::svp_cmd_t cmd;
	svp_pkg::svp_sts_t sts;
	logic [3:0] conf_limit_q;

	assign pready = 1'b1;
	assign prdata = (paddr == 1'b0) ? {28'd0, conf_limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			conf_limit_q <= 4'd3;
		else if (psel && penable && pwrite && paddr == 1'b0)
			conf_limit_q <= pwdata[3:0];
	end

	svp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .sts(sts)
	);

	svp_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_item(in_item), .conf_limit(conf_limit_q),
		.res(res), .res_strobe(res_strobe)
	);
endmodule

FILE: verif/svp_checker.sv
`timescale 1ns / 1ps
module svp_checker
	import svp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      busy,
	input  svp_in_t   in_item,
	input  svp_out_t  res,
	input  logic      res_strobe,
	input  logic      psel,
	input  logic      penable,
	input  logic      pwrite,
	input  logic [31:0] pwdata,
	input  logic      pready,
	output int        errors,
	output int        pending,
	output int        checked
);
	localparam int RING = 2 * QUEUE_DEPTH;
	localparam int INST_LIMIT = RING - 1;

	logic [TAG_BITS-1:0] ent_tag [ENTRIES];
	logic [3:0]          ent_conf [ENTRIES];
	logic [63:0]         ent_retired [ENTRIES];
	logic [63:0]         ent_stride [ENTRIES];
	int                  ent_inst [ENTRIES];
	logic [KEY_BITS-1:0] slot_key [QUEUE_DEPTH];
	int                  hd, tl;
	bit                  hd_ph, tl_ph;
	logic [3:0]          conf_limit;
	svp_out_t            expected_q[$];

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			ent_tag[i] = '0;
			ent_conf[i] = '0;
			ent_retired[i] = '0;
			ent_stride[i] = '0;
			ent_inst[i] = 0;
		end
		for (int i = 0; i < QUEUE_DEPTH; i++)
			slot_key[i] = '0;
		hd = 0;
		tl = 0;
		hd_ph = 0;
		tl_ph = 0;
		conf_limit = 4'd3;
		errors = 0;
		pending = 0;
		checked = 0;
	end

	function automatic int ring_pos(int p, bit ph);
		return ph * QUEUE_DEPTH + p;
	endfunction

	task automatic step_tail_back();
		logic [KEY_BITS-1:0] k;
		int ix;
		if (tl == 0) begin
			tl = QUEUE_DEPTH - 1;
			tl_ph = ~tl_ph;
		end else begin
			tl--;
		end
		k = slot_key[tl];
		ix = k[INDEX_BITS-1:0];
		if (ent_tag[ix] == k[KEY_BITS-1:INDEX_BITS] && ent_inst[ix] > 0)
			ent_inst[ix]--;
	endtask

	task automatic predict_value(input svp_in_t it, output svp_out_t o);
		int ix, occ, cnt, p, back, c;
		logic [TAG_BITS-1:0] tg;
		logic [KEY_BITS-1:0] key;
		logic [63:0] ns;
		bit hit, full;
		o = '0;
		ix = it.pc[2 +: INDEX_BITS];
		tg = it.pc[2+INDEX_BITS +: TAG_BITS];
		key = {tg, it.pc[2 +: INDEX_BITS]};
		occ = (ring_pos(tl, tl_ph) + RING - ring_pos(hd, hd_ph)) % RING;
		hit = (ent_tag[ix] == tg);
		case (it.mode)
		MODE_ALLOC: begin
			full = (occ == QUEUE_DEPTH);
			o.slot = tl[7:0];
			o.slot_phase = tl_ph;
			if (!full) begin
				slot_key[tl] = key;
				tl++;
				if (tl == QUEUE_DEPTH) begin
					tl = 0;
					tl_ph = ~tl_ph;
				end
			end
			if (hit) begin
				if (!full && ent_inst[ix] < INST_LIMIT)
					ent_inst[ix]++;
				o.hit = 1'b1;
				o.confident = (ent_conf[ix] == conf_limit);
				o.predicted_value = ent_retired[ix] + ent_stride[ix] * 64'(ent_inst[ix]);
			end
		end
		MODE_QUERY: begin
			o.stall_res = (occ == QUEUE_DEPTH) || ((QUEUE_DEPTH - occ) < int'(it.bundle_count));
		end
		MODE_TRAIN: begin
			if (occ != 0) begin
				hd++;
				if (hd == QUEUE_DEPTH) begin
					hd = 0;
					hd_ph = ~hd_ph;
				end
				if (hit) begin
					ns = it.value - ent_retired[ix];
					if (ns == ent_stride[ix]) begin
						c = ent_conf[ix] + 1;
						if (c >= conf_limit)
							c = conf_limit;
						ent_conf[ix] = c[3:0];
					end else begin
						ent_conf[ix] = '0;
						ent_stride[ix] = ns;
					end
					ent_retired[ix] = it.value;
					if (ent_inst[ix] > 0)
						ent_inst[ix]--;
				end else begin
					ent_tag[ix] = tg;
					ent_conf[ix] = '0;
					ent_retired[ix] = it.value;
					ent_stride[ix] = it.value;
					cnt = 0;
					p = hd;
					for (int n = 0; n < occ - 1; n++) begin
						if (slot_key[p] == key)
							cnt++;
						p = (p + 1 == QUEUE_DEPTH) ? 0 : p + 1;
					end
					ent_inst[ix] = (cnt > INST_LIMIT) ? INST_LIMIT : cnt;
				end
			end
		end
		MODE_SQUASH: begin
			for (int n = 0; n < occ; n++)
				step_tail_back();
		end
		MODE_RECOVER: begin
			back = (ring_pos(tl, tl_ph) + RING
				- ring_pos(it.target_entry, it.target_phase)) % RING;
			if (back <= occ)
				for (int n = 0; n < back; n++)
					step_tail_back();
		end
		default: ;
		endcase
	endtask

	always @(posedge clk) begin
		svp_out_t exp_res, got;
		if (arst_n) begin
			if (res_strobe) begin
				got = res;
				if (expected_q.size() == 0) begin
					$error("result with nothing expected: %p", got);
					errors++;
				end else begin
					exp_res = expected_q.pop_front();
					checked++;
					if (got.hit !== exp_res.hit) begin
						$error("hit: expected %0d got %0d", exp_res.hit, got.hit);
						errors++;
					end
					if (got.confident !== exp_res.confident) begin
						$error("confident: expected %0d got %0d",
							exp_res.confident, got.confident);
						errors++;
					end
					if (got.predicted_value !== exp_res.predicted_value) begin
						$error("predicted_value: expected %h got %h",
							exp_res.predicted_value, got.predicted_value);
						errors++;
					end
					if (got.slot !== exp_res.slot) begin
						$error("slot: expected %0d got %0d", exp_res.slot, got.slot);
						errors++;
					end
					if (got.slot_phase !== exp_res.slot_phase) begin
						$error("slot_phase: expected %0d got %0d",
							exp_res.slot_phase, got.slot_phase);
						errors++;
					end
					if (got.stall_res !== exp_res.stall_res) begin
						$error("stall_res: expected %0d got %0d",
							exp_res.stall_res, got.stall_res);
						errors++;
					end
				end
			end
			if (psel && penable && pwrite && pready)
				conf_limit = pwdata[3:0];
			if (start && !busy) begin
				predict_value(in_item, exp_res);
				expected_q.push_back(exp_res);
			end
			pending = expected_q.size();
		end
	end
endmodule

FILE: verif/stride_value_predictor_unit_test.sv
`timescale 1ns / 1ps
module stride_value_predictor_unit_test;
	import svp_pkg::*;

	localparam logic [0:0] ADDR_CONF_LIMIT = 1'b0;
	localparam int RING = 2 * QUEUE_DEPTH;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int NPC = 24;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	svp_in_t    in_item = '0;
	svp_out_t   res;
	logic       res_strobe;
	logic       psel = 1'b0;
	logic       penable = 1'b0;
	logic       pwrite = 1'b0;
	logic [0:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic       pready;
	int         errors, pending, checked;
	int         cycles = 0;
	int         sent = 0;

	// pointer mirror, used only to shape sensible sequences
	int          head_pos = 0, tail_pos = 0;
	logic [63:0] inflight[$];
	logic [63:0] pc_pool [NPC];
	logic [63:0] last_val [NPC];
	logic [63:0] pc_stride [NPC];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	stride_value_predictor_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.in_item(in_item), .res(res), .res_strobe(res_strobe),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	svp_checker u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.in_item(in_item), .res(res), .res_strobe(res_strobe),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pwdata(pwdata),
		.pready(pready), .errors(errors), .pending(pending), .checked(checked)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	function automatic svp_in_t noise_item(logic [2:0] m);
		svp_in_t it;
		it.mode = m;
		it.pc = {$urandom, $urandom};
		it.value = {$urandom, $urandom};
		it.target_entry = 8'($urandom);
		it.target_phase = 1'($urandom);
		it.bundle_count = 9'($urandom);
		return it;
	endfunction

	function automatic svp_in_t pool_item(logic [2:0] m, int id);
		svp_in_t it;
		it = noise_item(m);
		it.pc = pc_pool[id];
		return it;
	endfunction

	function automatic int pool_id(logic [63:0] pc);
		for (int i = 0; i < NPC; i++)
			if (pc_pool[i] == pc)
				return i;
		return -1;
	endfunction

	task automatic send(input svp_in_t it, input int gap);
		int back, tp;
		start <= 1'b1;
		in_item <= it;
		forever begin
			@(negedge clk);
			if (!busy)
				break;
		end
		@(posedge clk);
		sent++;
		case (it.mode)
		MODE_ALLOC:
			if (inflight.size() < QUEUE_DEPTH) begin
				inflight.push_back(it.pc);
				tail_pos = (tail_pos + 1) % RING;
			end
		MODE_TRAIN:
			if (inflight.size() > 0) begin
				void'(inflight.pop_front());
				head_pos = (head_pos + 1) % RING;
			end
		MODE_SQUASH: begin
			inflight.delete();
			tail_pos = head_pos;
		end
		MODE_RECOVER: begin
			tp = it.target_phase * QUEUE_DEPTH + it.target_entry;
			back = (tail_pos + RING - tp) % RING;
			if (back <= inflight.size()) begin
				repeat (back)
					void'(inflight.pop_back());
				tail_pos = tp;
			end
		end
		default: ;
		endcase
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		if (start) begin
			start <= 1'b0;
			@(posedge clk);
		end
		forever begin
			@(negedge clk);
			if (pending == 0 && !busy)
				break;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_conf_limit(input logic [3:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_CONF_LIMIT;
		pwdata <= {28'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic train_item(output svp_in_t it);
		int id;
		if (inflight.size() > 0 && $urandom_range(0, 99) < 85) begin
			id = pool_id(inflight[0]);
			it = noise_item(MODE_TRAIN);
			it.pc = inflight[0];
			if (id >= 0) begin
				if ($urandom_range(0, 19) == 0)
					pc_stride[id] = {$urandom, $urandom};
				if ($urandom_range(0, 15) != 0)
					last_val[id] = last_val[id] + pc_stride[id];
				else
					last_val[id] = {$urandom, $urandom};
				it.value = last_val[id];
			end
		end else begin
			it = pool_item(MODE_TRAIN, $urandom_range(0, NPC - 1));
		end
	endtask

	task automatic random_item(output svp_in_t it);
		int r, occ, n;
		r = $urandom_range(0, 99);
		occ = inflight.size();
		if (r < 42) begin
			if ($urandom_range(0, 15) == 0)
				it = noise_item(MODE_ALLOC);
			else
				it = pool_item(MODE_ALLOC, $urandom_range(0, NPC - 1));
		end else if (r < 76) begin
			train_item(it);
		end else if (r < 86) begin
			it = noise_item(MODE_QUERY);
			if ($urandom_range(0, 3) != 0)
				it.bundle_count = 9'($urandom_range(0, QUEUE_DEPTH));
		end else if (r < 96) begin
			it = noise_item(MODE_RECOVER);
			if ($urandom_range(0, 4) != 0) begin
				n = (tail_pos + RING - $urandom_range(0, occ > 8 ? 8 : occ)) % RING;
				it.target_entry = 8'(n % QUEUE_DEPTH);
				it.target_phase = 1'(n / QUEUE_DEPTH);
			end
		end else if (r < 98) begin
			it = noise_item(MODE_SQUASH);
		end else begin
			it = noise_item(3'($urandom_range(5, 7)));
		end
	endtask

	initial begin
		svp_in_t it;
		logic [3:0] conf_steps [4] = '{4'd15, 4'd1, 4'd8, 4'd3};
		int idx;
		logic [TAG_BITS-1:0] tg;

		for (int i = 0; i < NPC; i++) begin
			// groups of three share an index with different tags
			if (i % 3 == 0)
				idx = $urandom_range(0, ENTRIES - 1);
			tg = (i % 3 == 0) ? '0 : TAG_BITS'($urandom);
			pc_pool[i] = {$urandom, $urandom};
			pc_pool[i][2 +: INDEX_BITS] = INDEX_BITS'(idx);
			pc_pool[i][2+INDEX_BITS +: TAG_BITS] = tg;
			last_val[i] = {$urandom, $urandom};
			pc_stride[i] = (i % 2) ? 64'($urandom_range(0, 16)) : {$urandom, $urandom};
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send(noise_item(MODE_TRAIN), 0);
		it = noise_item(MODE_QUERY); it.bundle_count = '0;   send(it, 1);
		it.bundle_count = 9'd256;                            send(it, 0);
		it.bundle_count = 9'h1ff;                            send(it, 0);
		it = noise_item(MODE_ALLOC); it.pc = '0;             send(it, 0);
		it.pc = '1;                                          send(it, 2);
		it = noise_item(MODE_TRAIN); it.pc = '0; it.value = '1; send(it, 0);
		it.pc = '1; it.value = '0;                           send(it, 0);
		for (int k = 0; k < 4; k++) begin
			it = noise_item(MODE_ALLOC); it.pc = '1;         send(it, 0);
		end
		it = noise_item(MODE_RECOVER);
		it.target_entry = 8'(tail_pos % QUEUE_DEPTH);
		it.target_phase = 1'(tail_pos / QUEUE_DEPTH);        send(it, 0);
		it.target_entry = 8'((tail_pos - 2) % QUEUE_DEPTH);  send(it, 3);
		it = noise_item(MODE_RECOVER);
		it.target_entry = 8'(head_pos + 100);                send(it, 0);
		for (int k = 0; k < 2; k++) begin
			it = noise_item(MODE_TRAIN); it.pc = '1; it.value = 64'(k * 7); send(it, 0);
		end
		send(noise_item(MODE_SQUASH), 0);
		send(noise_item(3'd5), 0);
		send(noise_item(3'd6), 0);
		send(noise_item(3'd7), 0);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			if (ph > 0)
				write_conf_limit(conf_steps[ph-1]);
			for (int k = 0; k < 160; k++) begin
				if (k == 100 && ph % 2 == 1) begin
					// fill the queue and push past full with no gaps
					while (inflight.size() < QUEUE_DEPTH + 0)
						send(pool_item(MODE_ALLOC, $urandom_range(0, 2)), 0);
					send(pool_item(MODE_ALLOC, 0), 0);
					it = noise_item(MODE_QUERY); it.bundle_count = '0; send(it, 0);
					train_item(it);
					send(it, 0);
					send(pool_item(MODE_TRAIN, 1), pick_gap());
				end
				if (k == 130)
					drain();
				random_item(it);
				send(it, (k % 60 < 20) ? 0 : pick_gap());
			end
			drain();
		end

		$display("tb: %0d items sent, %0d results checked over five max_confidence settings",
			sent, checked);
		$display("tb: queue filled past full, trains on hit and miss, squash and recover");
		if (errors == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
